### rtl/assert_macros.svh
// Assertion helpers used by orb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks across reset.
`define ASSERT_NXT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/orb_pkg.sv
package orb_pkg;

    localparam int OP_W    = 2;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 7;
    // One list run returns at most this many entries.
    localparam int RUN_LIMIT = 64;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] entry_data;
        logic [CNT_W-1:0]  remove_count;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] entry_value;
        logic              last_of_run;
    } out_t;

    // Ring wrap: sum is always below twice the ring size.
    function automatic logic [CNT_W-1:0] ring_wrap(input logic [CNT_W:0]   sum,
                                                   input logic [CNT_W-1:0] size);
        logic [CNT_W:0] size_x;
        size_x = {1'b0, size};
        if (sum >= size_x) begin
            ring_wrap = CNT_W'(sum - size_x);
        end else begin
            ring_wrap = CNT_W'(sum);
        end
    endfunction

endpackage

### rtl/overwriting_ring_buffer_core.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------------
// input     | s_valid / s_ready  | s_operation, s_entry_data, s_remove_count
// result    | m_valid / m_ready  | m_entry_value, m_last_of_run
// config    | cfg_wr_en          | cfg_wr_data (ring capacity, no read-back)
//
// Append and remove are carried out as the back unit takes them.
// A list streams one entry per cycle while m_ready is high, set by the store's
// single registered read port; each entry then passes the output buffer.
// Up to two commands wait in the queue, so s_ready drops only when it is full.
// Reset clears the head, fill and the queues; the store itself is not cleared.
// A stall on m_ready pauses store reads; the queue takes input until full.
module overwriting_ring_buffer_core #(
    parameter int DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // ring capacity register
    input  logic                        cfg_wr_en,
    input  logic [orb_pkg::CNT_W-1:0]   cfg_wr_data,
    // commands in
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [orb_pkg::OP_W-1:0]    s_operation,
    input  logic [orb_pkg::DATA_W-1:0]  s_entry_data,
    input  logic [orb_pkg::CNT_W-1:0]   s_remove_count,
    // listed entries out
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [orb_pkg::DATA_W-1:0]  m_entry_value,
    output logic                        m_last_of_run
);
    import orb_pkg::*;

    // front -> back command transfer
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Front: takes input transfers, drops the unused opcode, queues the rest.
    orb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_entry_data   (s_entry_data),
        .s_remove_count (s_remove_count),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    // Back: owns head, fill and ring size, the entry store, and the
    // output buffer. A list holds off further commands until every read
    // of the run has been issued.
    orb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_value (m_entry_value),
        .m_last_of_run (m_last_of_run)
    );

endmodule

### rtl/orb_ram.sv
module orb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/orb_front.sv
module orb_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [orb_pkg::OP_W-1:0]    s_operation,
    input  logic [orb_pkg::DATA_W-1:0]  s_entry_data,
    input  logic [orb_pkg::CNT_W-1:0]   s_remove_count,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output orb_pkg::cmd_t               cmd
);
    import orb_pkg::*;

    // Two-entry command queue; slot 0 is the oldest.
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       q0_reg, q0_next;
    cmd_t       q1_reg, q1_next;
    logic       push, pop;
    logic [1:0] cnt_after_pop;
    cmd_t       new_cmd;

    assign s_ready   = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q0_reg;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        new_cmd.op           = s_operation;
        new_cmd.entry_data   = s_entry_data;
        new_cmd.remove_count = s_remove_count;
        // Unused opcode is taken and dropped here.
        push = s_valid && s_ready && (s_operation inside {OP_APPEND, OP_REMOVE, OP_LIST});
        cnt_after_pop = cnt_reg - {1'b0, pop};
        cnt_next      = cnt_after_pop + {1'b0, push};
        q0_next = q0_reg;
        q1_next = q1_reg;
        if (pop) begin
            q0_next = q1_reg;
        end
        if (push) begin
            if (cnt_after_pop == 2'd0) begin
                q0_next = new_cmd;
            end else begin
                q1_next = new_cmd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

### rtl/orb_back.sv
module orb_back #(
    parameter int DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [orb_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  orb_pkg::cmd_t               cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [orb_pkg::DATA_W-1:0]  m_entry_value,
    output logic                        m_last_of_run
);
    import orb_pkg::*;

    localparam int AW       = $clog2(DEPTH);
    localparam int SIZE_MAX = (DEPTH < RUN_LIMIT) ? DEPTH : RUN_LIMIT;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] rpos_reg, rpos_next;
    logic             infl_reg, infl_next;
    logic             infl_last_reg, infl_last_next;
    logic [1:0]       ocnt_reg, ocnt_next;
    out_t             o0_reg, o0_next;
    out_t             o1_reg, o1_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic             take_cmd, issue, out_pop, run_end;
    logic [1:0]       credit, ocnt_after_pop;
    logic [CNT_W-1:0] cfg_size;
    out_t             ret_item;

    orb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.entry_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ready     = (state_reg == ST_IDLE);
    assign take_cmd      = cmd_valid && cmd_ready;
    assign m_valid       = (ocnt_reg != 2'd0);
    assign m_entry_value = o0_reg.entry_value;
    assign m_last_of_run = o0_reg.last_of_run;
    assign out_pop       = m_valid && m_ready;

    // Entries held plus the one returning from the store must leave a free slot.
    assign credit = ocnt_reg + {1'b0, infl_reg};
    assign issue  = (state_reg == ST_LIST) && (credit <= (out_pop ? 2'd2 : 2'd1));
    assign run_end = (k_reg + CNT_W'(1) == fill_reg);

    assign ram_waddr = AW'(ring_wrap({1'b0, head_reg} + {1'b0, fill_reg}, size_reg));
    assign ram_raddr = AW'(rpos_reg);

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_size = CNT_W'(1);
        end else if (cfg_wr_data > CNT_W'(SIZE_MAX)) begin
            cfg_size = CNT_W'(SIZE_MAX);
        end else begin
            cfg_size = cfg_wr_data;
        end
    end

    always_comb begin
        state_next     = state_reg;
        size_next      = size_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        rpos_next      = rpos_reg;
        infl_next      = 1'b0;
        infl_last_next = infl_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (cfg_wr_en) begin
            size_next = cfg_size;
            head_next = '0;
            fill_next = '0;
        end else if (take_cmd) begin
            case (cmd.op)
                OP_APPEND: begin
                    ram_we = 1'b1;
                    if (fill_reg < size_reg) begin
                        fill_next = fill_reg + CNT_W'(1);
                    end else begin
                        head_next = ring_wrap({1'b0, head_reg} + 1'b1, size_reg);
                    end
                end
                OP_REMOVE: begin
                    if (cmd.remove_count >= fill_reg) begin
                        head_next = '0;
                        fill_next = '0;
                    end else begin
                        head_next = ring_wrap({1'b0, head_reg} + {1'b0, cmd.remove_count},
                                              size_reg);
                        fill_next = fill_reg - cmd.remove_count;
                    end
                end
                OP_LIST: begin
                    if (fill_reg != '0) begin
                        state_next = ST_LIST;
                        k_next     = '0;
                        rpos_next  = head_reg;
                    end
                end
                default: begin
                end
            endcase
        end else if (issue) begin
            ram_re         = 1'b1;
            infl_next      = 1'b1;
            infl_last_next = run_end;
            rpos_next      = ring_wrap({1'b0, rpos_reg} + 1'b1, size_reg);
            k_next         = k_reg + CNT_W'(1);
            if (run_end) begin
                state_next = ST_IDLE;
            end
        end
    end

    // Two-slot output buffer fed by the store's read port.
    always_comb begin
        ret_item.entry_value = ram_rdata;
        ret_item.last_of_run = infl_last_reg;
        ocnt_after_pop = ocnt_reg - {1'b0, out_pop};
        ocnt_next      = ocnt_after_pop + {1'b0, infl_reg};
        o0_next = o0_reg;
        o1_next = o1_reg;
        if (out_pop) begin
            o0_next = o1_reg;
        end
        if (infl_reg) begin
            if (ocnt_after_pop == 2'd0) begin
                o0_next = ret_item;
            end else begin
                o1_next = ret_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            size_reg  <= CNT_W'(SIZE_MAX);
            head_reg  <= '0;
            fill_reg  <= '0;
            infl_reg  <= 1'b0;
            ocnt_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            size_reg  <= size_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            infl_reg  <= infl_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        rpos_reg      <= rpos_next;
        infl_last_reg <= infl_last_next;
        o0_reg        <= o0_next;
        o1_reg        <= o1_next;
    end

endmodule

### rtl/orb_checker.sv
`include "assert_macros.svh"

module orb_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        cfg_wr_en,
    input logic [orb_pkg::CNT_W-1:0]   cfg_wr_data,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [orb_pkg::OP_W-1:0]    s_operation,
    input logic [orb_pkg::DATA_W-1:0]  s_entry_data,
    input logic [orb_pkg::CNT_W-1:0]   s_remove_count,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [orb_pkg::DATA_W-1:0]  m_entry_value,
    input logic                        m_last_of_run
);

    // Output buffer is empty and the queue open right after reset.
    `ASSERT_NXT_RST(a_rst_no_out, aclk, !aresetn, !m_valid, "result valid after reset")
    `ASSERT_NXT_RST(a_rst_ready, aclk, !aresetn, s_ready, "input not ready after reset")

    // The queue only fills through an input transfer.
    `ASSERT_IMP(a_full_by_xfer, aclk, aresetn, $fell(s_ready), $past(s_valid && s_ready), "s_ready fell without a transfer")

    // A stalled result holds.
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_entry_value) && $stable(m_last_of_run), "stalled result changed")

endmodule

bind overwriting_ring_buffer_core orb_checker u_orb_checker (.*);

### tb/orb_listing_monitor.sv
`timescale 1ns / 100ps

module orb_listing_monitor #(
    parameter int DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [orb_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [orb_pkg::OP_W-1:0]    s_operation,
    input  logic [orb_pkg::DATA_W-1:0]  s_entry_data,
    input  logic [orb_pkg::CNT_W-1:0]   s_remove_count,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [orb_pkg::DATA_W-1:0]  m_entry_value,
    input  logic                        m_last_of_run,
    output int                          mismatch_count,
    output int                          listed_pending
);
    import orb_pkg::*;

    localparam int POS_W = $clog2(DEPTH);

    logic [DATA_W-1:0] ring_words [DEPTH];
    logic [POS_W-1:0]  oldest_pos;
    logic [CNT_W-1:0]  stored_count;
    logic [CNT_W-1:0]  ring_capacity;
    out_t              listed_due [$];
    int                failures = 0;

    // Entries actually in use: zero acts as one, large values clip.
    function automatic int ring_span();
        int span;
        span = (ring_capacity == '0) ? 1 : int'(ring_capacity);
        if (span > DEPTH) span = DEPTH;
        if (span > RUN_LIMIT) span = RUN_LIMIT;
        return span;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    task automatic apply_command(input logic [OP_W-1:0]   op,
                                 input logic [DATA_W-1:0] word,
                                 input logic [CNT_W-1:0]  count);
        int   span;
        int   slot;
        int   k;
        out_t entry;
        span = ring_span();
        case (op)
            OP_APPEND: begin
                slot = (int'(oldest_pos) + int'(stored_count)) % span;
                ring_words[slot] = word;
                if (int'(stored_count) < span) begin
                    stored_count++;
                end else begin
                    // full: oldest word was just overwritten
                    oldest_pos = POS_W'((int'(oldest_pos) + 1) % span);
                end
            end
            OP_REMOVE: begin
                if (count >= stored_count) begin
                    stored_count = '0;
                    oldest_pos   = '0;
                end else begin
                    oldest_pos   = POS_W'((int'(oldest_pos) + int'(count)) % span);
                    stored_count = stored_count - count;
                end
            end
            OP_LIST: begin
                for (k = 0; k < int'(stored_count); k++) begin
                    entry.entry_value = ring_words[(int'(oldest_pos) + k) % span];
                    entry.last_of_run = (k + 1 == int'(stored_count));
                    listed_due.push_back(entry);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            oldest_pos    = '0;
            stored_count  = '0;
            ring_capacity = CNT_W'(RUN_LIMIT);
            listed_due.delete();
        end else begin
            if (cfg_wr_en) begin
                ring_capacity = cfg_wr_data;
                oldest_pos    = '0;
                stored_count  = '0;
            end
            // results first: nothing accepted at this edge can show yet
            if (m_valid && m_ready) begin
                if (listed_due.size() == 0) begin
                    note_failure($sformatf("unexpected entry %h last %b",
                                           m_entry_value, m_last_of_run));
                end else begin
                    want = listed_due.pop_front();
                    if (want.entry_value !== m_entry_value ||
                        want.last_of_run !== m_last_of_run) begin
                        note_failure($sformatf("entry mismatch: expected %h last %b, got %h last %b",
                                               want.entry_value, want.last_of_run,
                                               m_entry_value, m_last_of_run));
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_command(s_operation, s_entry_data, s_remove_count);
            end
        end
        listed_pending <= listed_due.size();
        mismatch_count <= failures;
    end

endmodule

### tb/overwriting_ring_buffer_core_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the overwriting ring buffer. The listing monitor
// beside the block tracks every transfer and checks every listed entry.
module overwriting_ring_buffer_core_tb;
    import orb_pkg::*;

    localparam int DEPTH           = 64;
    localparam int DRAIN_CYCLES    = 16;      // queue of two plus the unit in flight
    localparam int HOLD_CYCLES     = 300;     // long receiver hold-off
    localparam int ITEMS_PER_PHASE = 42;
    localparam int CYCLE_LIMIT     = 900_000;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data    = '0;
    logic                s_valid        = 1'b0;
    logic [OP_W-1:0]     s_operation    = OP_APPEND;
    logic [DATA_W-1:0]   s_entry_data   = '0;
    logic [CNT_W-1:0]    s_remove_count = '0;
    logic                m_ready        = 1'b0;
    wire                 s_ready;
    wire                 m_valid;
    wire  [DATA_W-1:0]   m_entry_value;
    wire                 m_last_of_run;

    logic                bursts_on      = 1'b0;  // random idling on both sides
    logic                hold_req       = 1'b0;  // asks the receiver for the long hold
    bit                  long_hold_done = 1'b0;
    int                  mismatch_count;
    int                  listed_pending;
    int                  cycle_count    = 0;

    // Capacity per random phase: extremes, out-of-range codes, and one slot
    // (index 5) that gets a random value at run time.
    logic [CNT_W-1:0] capacity_plan [8] = '{7'd1, 7'd64, 7'd0, 7'd127,
                                           7'd2, 7'd0, 7'd17, 7'd64};

    always #1 aclk = ~aclk;

    overwriting_ring_buffer_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_entry_data   (s_entry_data),
        .s_remove_count (s_remove_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_value  (m_entry_value),
        .m_last_of_run  (m_last_of_run)
    );

    orb_listing_monitor #(
        .DEPTH(DEPTH)
    ) i_listing_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_entry_data   (s_entry_data),
        .s_remove_count (s_remove_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_value  (m_entry_value),
        .m_last_of_run  (m_last_of_run),
        .mismatch_count (mismatch_count),
        .listed_pending (listed_pending)
    );

    // Offer one command and hold it until the transfer. Valid stays high on
    // return so back-to-back commands need no extra NBA on s_valid.
    task automatic push_command(input logic [OP_W-1:0]   op,
                                input logic [DATA_W-1:0] word,
                                input logic [CNT_W-1:0]  count);
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_entry_data   <= word;
        s_remove_count <= count;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering, let every listed entry come out, then give the queue
    // time to retire trailing appends/removes that produce nothing.
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (listed_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver side: random back-pressure bursts, and once the long hold-off
    // so the list stalls, the command queue fills and s_ready drops.
    always begin
        @(posedge aclk);
        if (hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            m_ready <= 1'b1;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("overwriting_ring_buffer_core_tb: errors");
        $finish;
    end

    initial begin
        int                phase;
        int                n;
        int                roll;
        logic [DATA_W-1:0] word;
        logic [CNT_W-1:0]  count;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, at the reset capacity of 64 ---
        push_command(OP_LIST,   '0, '0);           // empty ring: no output
        push_command(OP_UNUSED, '1, 7'd64);        // unused code is dropped
        push_command(OP_APPEND, '0, '0);
        push_command(OP_APPEND, '1, '0);
        push_command(OP_LIST,   '0, '0);
        push_command(OP_REMOVE, '1, '0);           // remove of zero: no change
        push_command(OP_LIST,   '1, '1);
        settle_block();

        // --- directed, small ring: wrap, overwrite, removes ---
        write_capacity(7'd4);
        push_command(OP_LIST,   '0, '0);           // write emptied the ring
        push_command(OP_APPEND, 64'h5555_5555_5555_5555, '0);
        push_command(OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        push_command(OP_APPEND, 64'h0123_4567_89AB_CDEF, '0);
        push_command(OP_APPEND, 64'hFEDC_BA98_7654_3210, '0);
        push_command(OP_APPEND, 64'h8000_0000_0000_0001, '0);  // full: drops oldest
        push_command(OP_LIST,   '0, '0);
        push_command(OP_REMOVE, '0, 7'd1);
        push_command(OP_LIST,   '0, '0);
        push_command(OP_REMOVE, '0, 7'd3);         // exactly the fill, head nonzero
        push_command(OP_APPEND, 64'h7FFF_FFFF_FFFF_FFFE, '0);
        push_command(OP_LIST,   '0, '0);
        push_command(OP_REMOVE, '0, 7'd64);        // count far above the fill
        push_command(OP_LIST,   '0, '0);

        // --- random phases, one capacity each ---
        for (phase = 0; phase < 8; phase++) begin
            settle_block();
            // last phase runs with no idling; odd phases may run without it
            if (phase == 7) begin
                bursts_on <= 1'b0;
            end else if (phase % 2 == 0) begin
                bursts_on <= 1'b1;
            end else begin
                bursts_on <= 1'($urandom_range(0, 1));
            end
            write_capacity(phase == 5 ? CNT_W'($urandom_range(3, 63)) : capacity_plan[phase]);
            push_command(OP_LIST, '0, '0);         // must be empty after the write

            if (phase == 1) begin
                // receiver goes quiet while a long list and more commands queue up
                hold_req <= 1'b1;
                repeat (10) push_command(OP_APPEND, {$urandom(), $urandom()}, '0);
                push_command(OP_LIST, '0, '0);
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                case ($urandom_range(0, 15))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = {$urandom(), $urandom()};
                endcase
                count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 64))
                                                    : CNT_W'($urandom_range(0, 3));
                if (roll < 60) begin
                    push_command(OP_APPEND, word, count);
                end else if (roll < 80) begin
                    push_command(OP_REMOVE, word, count);
                end else if (roll < 95) begin
                    push_command(OP_LIST, word, count);
                end else begin
                    push_command(OP_UNUSED, word, count);
                end
            end
        end

        settle_block();
        if (mismatch_count == 0) begin
            $display("overwriting_ring_buffer_core_tb: clean");
        end else begin
            $display("overwriting_ring_buffer_core_tb: errors");
        end
        $finish;
    end

endmodule

### overwriting_ring_buffer_core.f
+incdir+rtl
rtl/orb_pkg.sv
rtl/orb_ram.sv
rtl/orb_front.sv
rtl/orb_back.sv
rtl/overwriting_ring_buffer_core.sv
rtl/orb_checker.sv
tb/orb_listing_monitor.sv
tb/overwriting_ring_buffer_core_tb.sv
